>>> rtl/qesc_pkg.sv
`default_nettype none

package qesc_pkg;

  typedef enum logic [2:0] {
    OP_SAMPLE   = 3'd0,
    OP_READ     = 3'd1,
    OP_READ_CLR = 3'd2,
    OP_CLEAR    = 3'd3,
    OP_SPEED    = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    KIND_NONE,
    KIND_SAMPLE,
    KIND_READ,
    KIND_READ_CLR,
    KIND_CLEAR,
    KIND_SPEED
  } kind_e;

  typedef enum logic [1:0] {
    REG_PPR      = 2'd0,
    REG_INTERVAL = 2'd1,
    REG_FILTER   = 2'd2
  } reg_e;

  typedef enum logic {
    BK_IDLE,
    BK_SPEED
  } back_state_e;

  typedef enum logic [1:0] {
    DV_IDLE,
    DV_MUL,
    DV_RUN,
    DV_DONE
  } div_state_e;

  localparam logic [15:0] PPR_RESET      = 16'd0;
  localparam logic [15:0] INTERVAL_RESET = 16'd10;
  localparam logic [3:0]  FILTER_RESET   = 4'd6;
  localparam logic [3:0]  FILTER_MAX     = 4'd8;
  localparam logic [23:0] RPM_Q8_SCALE   = 24'd15360000;
  localparam int unsigned VALUE_W        = 16;
  localparam int unsigned SPEED_W        = 38;
  localparam int unsigned DEN_W          = 34;

  typedef struct packed {
    kind_e      kind;
    logic       motor;
    logic [3:0] pins;
  } req_t;

  typedef struct packed {
    logic start;
    logic take;
  } div_ctl_t;

  function automatic logic [1:0] phase_of(input logic a, input logic b);
    logic [1:0] p;
    if (a) begin
      p = b ? 2'd2 : 2'd1;
    end else begin
      p = b ? 2'd3 : 2'd0;
    end
    return p;
  endfunction

endpackage

`default_nettype wire

>>> rtl/qesc_if.sv
`default_nettype none

interface qesc_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] operation;
  logic       motor_select;
  logic       pin_a_first;
  logic       pin_b_first;
  logic       pin_a_second;
  logic       pin_b_second;

  modport source (
    output valid, operation, motor_select, pin_a_first, pin_b_first,
           pin_a_second, pin_b_second,
    input  ready
  );
  modport sink (
    input  valid, operation, motor_select, pin_a_first, pin_b_first,
           pin_a_second, pin_b_second,
    output ready
  );
endinterface

interface qesc_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] count_value;
  logic signed [37:0] speed_rpm_q8;

  modport source (
    output valid, count_value, speed_rpm_q8,
    input  ready
  );
  modport sink (
    input  valid, count_value, speed_rpm_q8,
    output ready
  );
endinterface

`default_nettype wire

>>> rtl/qesc_front.sv
`default_nettype none

module qesc_front import qesc_pkg::*; #(
  parameter int unsigned NUM_MOTORS = 2
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  qesc_in_if.sink   req_i,
  input  wire logic pop_i,
  output logic      q_valid_o,
  output req_t      q_req_o
);

  req_t       mem_q [2];
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  logic [1:0] fill_q;
  logic       push;
  logic       pop;
  logic       motor_ok;
  req_t       dec;

  assign motor_ok = (NUM_MOTORS > 1) || !req_i.motor_select;

  always_comb begin
    dec.motor = req_i.motor_select;
    dec.pins  = {req_i.pin_b_second, req_i.pin_a_second, req_i.pin_b_first, req_i.pin_a_first};
    case (op_e'(req_i.operation))
      OP_SAMPLE:   dec.kind = KIND_SAMPLE;
      OP_READ:     dec.kind = motor_ok ? KIND_READ : KIND_NONE;
      OP_READ_CLR: dec.kind = motor_ok ? KIND_READ_CLR : KIND_NONE;
      OP_CLEAR:    dec.kind = motor_ok ? KIND_CLEAR : KIND_NONE;
      OP_SPEED:    dec.kind = motor_ok ? KIND_SPEED : KIND_NONE;
      default:     dec.kind = KIND_NONE;
    endcase
  end

  assign req_i.ready = (fill_q != 2'd2);
  assign push        = req_i.valid && req_i.ready;
  assign q_valid_o   = (fill_q != 2'd0);
  assign pop         = pop_i && q_valid_o;
  assign q_req_o     = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= dec;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (push && !pop) begin
        fill_q <= fill_q + 2'd1;
      end else if (pop && !push) begin
        fill_q <= fill_q - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/qesc_div.sv
`default_nettype none

module qesc_div import qesc_pkg::*; #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire div_ctl_t               ctl_i,
  input  wire logic                   neg_i,
  input  wire logic [COUNT_WIDTH-1:0] mag_i,
  input  wire logic [15:0]            ppr_i,
  input  wire logic [15:0]            interval_i,
  output logic                        done_o,
  output logic [SPEED_W-1:0]          speed_o
);

  localparam int unsigned NW  = COUNT_WIDTH + 24;
  localparam int unsigned SW  = (NW + 1 > SPEED_W) ? NW + 1 : SPEED_W;
  localparam int unsigned STW = $clog2(NW);

  div_state_e              state_q, state_d;
  logic                    neg_q;
  logic [COUNT_WIDTH-1:0]  mag_q;
  logic [15:0]             ppr_q;
  logic [15:0]             interval_q;
  logic [NW-1:0]           num_q;
  logic [DEN_W-1:0]        den_q;
  logic [DEN_W-1:0]        rem_q;
  logic [STW-1:0]          step_q;
  logic [NW-1:0]           prod;
  logic [31:0]             den_prod;
  logic [DEN_W:0]          rem_sh;
  logic                    fits;
  logic [SW-1:0]           q_wide;
  logic [SW-1:0]           q_signed;

  assign prod     = mag_q * RPM_Q8_SCALE;
  assign den_prod = ppr_q * interval_q;
  assign rem_sh   = {rem_q, num_q[NW-1]};
  assign fits     = rem_sh >= {1'b0, den_q};
  assign q_wide   = SW'(num_q);
  assign q_signed = neg_q ? (~q_wide + SW'(1)) : q_wide;
  assign speed_o  = q_signed[SPEED_W-1:0];
  assign done_o   = (state_q == DV_DONE);

  always_comb begin
    state_d = state_q;
    case (state_q)
      DV_IDLE: if (ctl_i.start) begin
        state_d = DV_MUL;
      end
      DV_MUL: begin
        state_d = (den_prod == 32'd0) ? DV_DONE : DV_RUN;
      end
      DV_RUN: if (step_q == STW'(NW - 1)) begin
        state_d = DV_DONE;
      end
      DV_DONE: if (ctl_i.take) begin
        state_d = DV_IDLE;
      end
      default: state_d = DV_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DV_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      DV_IDLE: if (ctl_i.start) begin
        neg_q      <= neg_i;
        mag_q      <= mag_i;
        ppr_q      <= ppr_i;
        interval_q <= interval_i;
      end
      DV_MUL: begin
        num_q  <= (den_prod == 32'd0) ? '0 : prod;
        den_q  <= {den_prod, 2'b00};
        rem_q  <= '0;
        step_q <= '0;
      end
      DV_RUN: begin
        rem_q  <= fits ? DEN_W'(rem_sh - {1'b0, den_q}) : rem_sh[DEN_W-1:0];
        num_q  <= {num_q[NW-2:0], fits};
        step_q <= step_q + STW'(1);
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/qesc_back.sv
`default_nettype none

module qesc_back import qesc_pkg::*; #(
  parameter int unsigned COUNT_WIDTH = 16,
  parameter int unsigned NUM_MOTORS  = 2
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic [15:0] ppr_i,
  input  wire logic [15:0] interval_i,
  input  wire logic [3:0]  filter_i,
  input  wire logic        q_valid_i,
  input  wire req_t        q_req_i,
  output logic             q_pop_o,
  qesc_out_if.source       rsp_o
);

  localparam int unsigned NP = 2 * NUM_MOTORS;

  back_state_e              state_q, state_d;
  logic [COUNT_WIDTH-1:0]   cnt_q [NUM_MOTORS];
  logic [COUNT_WIDTH-1:0]   cnt_d [NUM_MOTORS];
  logic [NP-1:0]            lvl_q, lvl_d;
  logic [2:0]               run_q [NP];
  logic [2:0]               run_d [NP];
  logic [NP-1:0]            raw;
  logic [1:0]               step [NUM_MOTORS];
  logic [3:0]               need;
  logic [COUNT_WIDTH-1:0]   sel_cnt;
  logic signed [31:0]       sel_ext;
  logic [VALUE_W-1:0]       sel_val;
  logic                     sel_neg;
  logic [COUNT_WIDTH-1:0]   sel_mag;
  logic [VALUE_W-1:0]       cval_q, cval_d;
  logic                     out_valid_q;
  logic [VALUE_W-1:0]       out_cnt_q;
  logic [SPEED_W-1:0]       out_spd_q;
  logic                     load_ok;
  logic                     load;
  logic [VALUE_W-1:0]       load_cnt;
  logic [SPEED_W-1:0]       load_spd;
  logic                     exec_sample;
  logic                     clr;
  div_ctl_t                 div_ctl;
  logic                     div_done;
  logic [SPEED_W-1:0]       div_speed;

  for (genvar i = 0; i < NP; i++) begin : g_raw
    if (i < 4) begin : g_pin
      assign raw[i] = q_req_i.pins[i];
    end else begin : g_zero
      assign raw[i] = 1'b0;
    end
  end

  assign need = (filter_i == 4'd0) ? 4'd1 : ((filter_i > FILTER_MAX) ? FILTER_MAX : filter_i);

  always_comb begin
    sel_cnt = cnt_q[0];
    for (int m = 0; m < NUM_MOTORS; m++) begin
      if (m == int'(q_req_i.motor)) begin
        sel_cnt = cnt_q[m];
      end
    end
  end

  assign sel_ext = 32'($signed(sel_cnt));
  assign sel_val = sel_ext[VALUE_W-1:0];
  assign sel_neg = sel_cnt[COUNT_WIDTH-1];
  assign sel_mag = sel_neg ? (~sel_cnt + COUNT_WIDTH'(1)) : sel_cnt;

  assign load_ok = !out_valid_q || rsp_o.ready;

  always_comb begin
    state_d     = state_q;
    q_pop_o     = 1'b0;
    div_ctl     = '0;
    load        = 1'b0;
    load_cnt    = '0;
    load_spd    = '0;
    cval_d      = cval_q;
    exec_sample = 1'b0;
    clr         = 1'b0;
    case (state_q)
      BK_IDLE: if (q_valid_i) begin
        if (q_req_i.kind == KIND_SPEED) begin
          q_pop_o       = 1'b1;
          div_ctl.start = 1'b1;
          cval_d        = sel_val;
          clr           = 1'b1;
          state_d       = BK_SPEED;
        end else if (load_ok) begin
          q_pop_o = 1'b1;
          load    = 1'b1;
          case (q_req_i.kind)
            KIND_SAMPLE: exec_sample = 1'b1;
            KIND_READ: load_cnt = sel_val;
            KIND_READ_CLR: begin
              load_cnt = sel_val;
              clr      = 1'b1;
            end
            KIND_CLEAR: clr = 1'b1;
            default: ;
          endcase
        end
      end
      BK_SPEED: if (div_done && load_ok) begin
        load         = 1'b1;
        load_cnt     = cval_q;
        load_spd     = div_speed;
        div_ctl.take = 1'b1;
        state_d      = BK_IDLE;
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_comb begin
    lvl_d = lvl_q;
    for (int i = 0; i < NP; i++) begin
      run_d[i] = run_q[i];
      if (exec_sample) begin
        if (raw[i] == lvl_q[i]) begin
          run_d[i] = 3'd0;
        end else if (({1'b0, run_q[i]} + 4'd1) >= need) begin
          lvl_d[i] = raw[i];
          run_d[i] = 3'd0;
        end else begin
          run_d[i] = run_q[i] + 3'd1;
        end
      end
    end
  end

  always_comb begin
    for (int m = 0; m < NUM_MOTORS; m++) begin
      step[m]  = phase_of(lvl_d[2*m], lvl_d[2*m+1]) - phase_of(lvl_q[2*m], lvl_q[2*m+1]);
      cnt_d[m] = cnt_q[m];
      if (exec_sample && step[m] == 2'd1) begin
        cnt_d[m] = cnt_q[m] + COUNT_WIDTH'(1);
      end else if (exec_sample && step[m] == 2'd3) begin
        cnt_d[m] = cnt_q[m] - COUNT_WIDTH'(1);
      end
      if (clr && m == int'(q_req_i.motor)) begin
        cnt_d[m] = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      lvl_q       <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NP; i++) begin
        run_q[i] <= 3'd0;
      end
      for (int m = 0; m < NUM_MOTORS; m++) begin
        cnt_q[m] <= '0;
      end
    end else begin
      state_q <= state_d;
      lvl_q   <= lvl_d;
      run_q   <= run_d;
      cnt_q   <= cnt_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cval_q <= cval_d;
    if (load) begin
      out_cnt_q <= load_cnt;
      out_spd_q <= load_spd;
    end
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.count_value  = out_cnt_q;
  assign rsp_o.speed_rpm_q8 = out_spd_q;

  qesc_div #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (div_ctl),
    .neg_i      (sel_neg),
    .mag_i      (sel_mag),
    .ppr_i      (ppr_i),
    .interval_i (interval_i),
    .done_o     (div_done),
    .speed_o    (div_speed)
  );

endmodule

`default_nettype wire

>>> rtl/quadrature_encoder_speed_counter.sv
// Channel  Modport       Handshake      Payload
// req_i    sink          valid/ready    operation, motor_select, four pin levels
// rsp_o    source        valid/ready    count_value, speed_rpm_q8
// apb      psel/penable  pready high    pulses_per_rev, sample_interval_ms, filter_samples
//
// Sample, read, read-and-clear and clear requests are done in the idle back end once the output can load.
// A speed request uses the bit-serial divider, which produces one quotient bit per cycle after
// a multiply state; its result is loaded once the output register is free.
// With a zero ppr or interval the divide loop is skipped and the speed result is zero.
// Reset clears counters, filters, queue and output; registers return to 0, 10 and 6.
// A two-entry queue and the output register let either side stall independently.
`default_nettype none

module quadrature_encoder_speed_counter import qesc_pkg::*; #(
  parameter int unsigned COUNT_WIDTH = 16,
  parameter int unsigned NUM_MOTORS  = 2
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  qesc_in_if.sink          req_i,
  qesc_out_if.source       rsp_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [15:0] ppr_q;
  logic [15:0] interval_q;
  logic [3:0]  filter_q;
  logic        cfg_wr;
  logic        q_valid;
  logic        q_pop;
  req_t        q_req;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ppr_q      <= PPR_RESET;
      interval_q <= INTERVAL_RESET;
      filter_q   <= FILTER_RESET;
    end else if (cfg_wr) begin
      case (reg_e'(paddr[3:2]))
        REG_PPR:      ppr_q      <= pwdata[15:0];
        REG_INTERVAL: interval_q <= pwdata[15:0];
        REG_FILTER:   filter_q   <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_e'(paddr[3:2]))
      REG_PPR:      prdata = {16'd0, ppr_q};
      REG_INTERVAL: prdata = {16'd0, interval_q};
      REG_FILTER:   prdata = {28'd0, filter_q};
      default:      prdata = 32'd0;
    endcase
  end

  qesc_front #(
    .NUM_MOTORS(NUM_MOTORS)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (req_i),
    .pop_i     (q_pop),
    .q_valid_o (q_valid),
    .q_req_o   (q_req)
  );

  qesc_back #(
    .COUNT_WIDTH(COUNT_WIDTH),
    .NUM_MOTORS (NUM_MOTORS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ppr_i      (ppr_q),
    .interval_i (interval_q),
    .filter_i   (filter_q),
    .q_valid_i  (q_valid),
    .q_req_i    (q_req),
    .q_pop_o    (q_pop),
    .rsp_o      (rsp_o)
  );

endmodule

`default_nettype wire
